@@ rtl/core/bms_pkg.sv @@
`default_nettype none

package bms_pkg;

  // Default sizes of the note memory
  localparam int DEF_TRACKS = 16;
  localparam int DEF_NOTES  = 256;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Arithmetic constants
  localparam int          TOTAL_W     = 24;
  localparam int          TONE_CLOCK  = 1000000;
  localparam logic [15:0] BASE_PERIOD = 16'd499;
  localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
  localparam logic [6:0]  PCT_FULL    = 7'd100;
  localparam logic [6:0]  TRACK_CAP   = 7'd16;

  // Shared divider widths
  localparam int DIV_NW = 31;
  localparam int DIV_DW = 24;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_PLAY = 2'd1,
    OP_STOP = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic {
    REG_TRACK_COUNT = 1'b0,
    REG_BACKLIGHT   = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_NOTE,
    S_TDIV,
    S_CONS,
    S_PCT,
    S_PDIV,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/bms_if.sv @@
`default_nettype none

// Request channel: one command or tick per transaction
interface bms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  track;
  logic [7:0]  note_index;
  logic [15:0] note_freq;
  logic [15:0] note_dur;
  logic [15:0] tick_ms;

  modport source (output valid, operation, track, note_index, note_freq, note_dur, tick_ms,
                  input ready);
  modport sink   (input valid, operation, track, note_index, note_freq, note_dur, tick_ms,
                  output ready);
endinterface

// Response channel: one status snapshot per request
interface bms_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tone_reload;
  logic [14:0] tone_compare;
  logic [15:0] backlight_compare;
  logic        playing;
  logic        finished;
  logic [23:0] elapsed_ms;
  logic [23:0] total_ms;
  logic [6:0]  progress_pct;
  logic        status;

  modport source (output valid, tone_reload, tone_compare, backlight_compare, playing,
                  finished, elapsed_ms, total_ms, progress_pct, status,
                  input ready);
  modport sink   (input valid, tone_reload, tone_compare, backlight_compare, playing,
                  finished, elapsed_ms, total_ms, progress_pct, status,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/buzzer_melody_sequencer_unit.sv @@
`default_nettype none

// Buzzer melody sequencer. Each request transaction (load note, play, stop or
// tick) yields one response transaction with the buzzer timer period and duty
// compare, the backlight compare, play state, elapsed and total time and the
// progress in percent. Requests are handled one at a time; a new request is
// taken as soon as the previous response sits in the output register. Load,
// play and stop execute, then run the progress division when it is needed.
// A tick reads each note it walks into from the note memory; a sounding note
// also runs the shared divider for 1000000/freq, a rest note does not; the
// progress division follows when it is needed. Notes live in a TRACKS*NOTES
// entry memory and per-track length and total in a TRACKS entry memory with a
// valid flag per track, so no clearing pass is needed after reset.
module buzzer_melody_sequencer_unit #(
  parameter int TRACKS = bms_pkg::DEF_TRACKS,
  parameter int NOTES  = bms_pkg::DEF_NOTES
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [bms_pkg::CFG_AW-1:0] paddr,
  input  wire logic [bms_pkg::CFG_DW-1:0] pwdata,
  output logic      [bms_pkg::CFG_DW-1:0] prdata,
  output logic                           pready,
  bms_in_if.sink                         req,
  bms_out_if.source                      rsp
);
  import bms_pkg::*;

  localparam int TW  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int LW  = $clog2(NOTES + 1);
  localparam int NAW = $clog2(TRACKS * NOTES);
  localparam int IW  = LW + TOTAL_W;

  function automatic logic [TOTAL_W-1:0] sat_add24(input logic [TOTAL_W-1:0] a,
                                                   input logic [15:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
  endfunction

  // Configuration registers
  logic [4:0]  track_count;
  logic [15:0] backlight_level;
  reg_idx_t    cfg_idx;

  // Sequencer and item registers
  state_t      state, state_next;
  op_t         op;
  logic [3:0]  trk;
  logic [7:0]  idx;
  logic [15:0] du;
  logic [15:0] req_freq_q;
  logic [15:0] dt_rem;
  logic        ld_rng;
  logic        play_ok;
  logic        rd_vld;

  // Playback state
  logic                active;
  logic                done_flag;
  logic [TW-1:0]       cur_track;
  logic [LW-1:0]       next_note;
  logic [15:0]         note_left;
  logic [TOTAL_W-1:0]  played;
  logic [15:0]         period;
  logic [14:0]         duty;
  logic [LW-1:0]       cur_len;
  logic [TOTAL_W-1:0]  cur_tot;
  logic                status;
  logic [6:0]          pct;
  logic [TRACKS-1:0]   info_vld;

  // Memory ports
  logic [TW-1:0]  info_raddr;
  logic [IW-1:0]  info_rdata;
  logic           mem_we;
  logic [NAW-1:0] note_waddr, note_raddr;
  logic [31:0]    note_rdata;

  // Combinational helpers
  logic               in_fire, out_free;
  logic [6:0]         play_cnt;
  logic               in_trk_rng, in_play_ok;
  logic [LW-1:0]      rd_len, base_len, new_len;
  logic [TOTAL_W-1:0] rd_tot, base_tot, new_tot;
  logic               ld_hit;
  logic               short_dt;
  logic [TOTAL_W-1:0] cons_played;
  logic               walk_end;
  logic [15:0]        nf, nd;
  logic               needs_div;

  // Divider hookup
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;
  logic [15:0]       tone_per, tone_pm1;

  // APB configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      track_count     <= '0;
      backlight_level <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        REG_TRACK_COUNT: track_count     <= pwdata[4:0];
        REG_BACKLIGHT:   backlight_level <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TRACK_COUNT: prdata = {27'd0, track_count};
      REG_BACKLIGHT:   prdata = {16'd0, backlight_level};
      default:         prdata = '0;
    endcase
  end

  // Request decode at acceptance
  assign in_fire   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  always_comb begin
    play_cnt = {2'd0, track_count};
    if (play_cnt > TRACK_CAP) play_cnt = TRACK_CAP;
    if (int'(play_cnt) > TRACKS) play_cnt = 7'(TRACKS);
  end

  assign in_trk_rng = int'(req.track) < TRACKS;
  assign in_play_ok = int'(req.track) < int'(play_cnt);

  always_comb begin
    info_raddr = cur_track;
    if ((op_t'(req.operation) == OP_LOAD && in_trk_rng) ||
        (op_t'(req.operation) == OP_PLAY && in_play_ok)) begin
      info_raddr = TW'(req.track);
    end
  end

  // Track info read and load update
  assign rd_len   = rd_vld ? info_rdata[IW-1:TOTAL_W] : '0;
  assign rd_tot   = rd_vld ? info_rdata[TOTAL_W-1:0] : '0;
  assign base_len = (idx == 8'd0) ? '0 : rd_len;
  assign base_tot = (idx == 8'd0) ? '0 : rd_tot;
  assign ld_hit   = (op == OP_LOAD) && ld_rng && (int'(idx) == int'(base_len));
  assign new_len  = LW'({1'b0, idx} + 9'd1);
  assign new_tot  = sat_add24(base_tot, du);
  assign mem_we   = (state == S_EXEC) && ld_hit;

  assign note_waddr = NAW'(trk) * NAW'(NOTES) + NAW'(idx);
  assign note_raddr = NAW'(cur_track) * NAW'(NOTES) + NAW'(next_note);

  bms_ram #(.W(IW), .D(TRACKS)) u_info_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (TW'(trk)),
    .wdata ({new_len, new_tot}),
    .raddr (info_raddr),
    .rdata (info_rdata)
  );

  bms_ram #(.W(32), .D(TRACKS * NOTES)) u_note_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (note_waddr),
    .wdata ({req_freq_q, du}),
    .raddr (note_raddr),
    .rdata (note_rdata)
  );

  // Time consumption against the current note
  assign short_dt    = dt_rem < note_left;
  assign cons_played = sat_add24(played, short_dt ? dt_rem : note_left);
  assign walk_end    = (int'(next_note) >= int'(cur_len)) || (int'(next_note) >= NOTES);
  assign nf          = note_rdata[31:16];
  assign nd          = note_rdata[15:0];
  assign needs_div   = !done_flag && (cur_tot != '0) && (played < cur_tot);

  // Tone period from the divider quotient
  always_comb begin
    if (div_quo < DIV_NW'(2)) tone_per = 16'd2;
    else if (div_quo > DIV_NW'(65535)) tone_per = 16'hFFFF;
    else tone_per = div_quo[15:0];
  end
  assign tone_pm1 = tone_per - 16'd1;

  // Shared divider: tone period or progress
  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_NW'(TONE_CLOCK);
    div_den   = {8'd0, nf};
    if (state == S_NOTE && nf != 16'd0) begin
      div_start = 1'b1;
    end else if (state == S_PCT && needs_div) begin
      div_start = 1'b1;
      div_num   = DIV_NW'(played) * DIV_NW'(PCT_FULL);
      div_den   = cur_tot;
    end
  end

  bms_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_EXEC;
      S_EXEC: begin
        if (op == OP_TICK && active && dt_rem != 16'd0) begin
          state_next = short_dt ? S_PCT : S_WALK;
        end else begin
          state_next = S_PCT;
        end
      end
      S_WALK: state_next = walk_end ? S_PCT : S_NOTE;
      S_NOTE: begin
        if (nf == 16'd0 && nd == 16'd0) state_next = S_PCT;
        else if (nf == 16'd0)           state_next = S_CONS;
        else                            state_next = S_TDIV;
      end
      S_TDIV: if (div_done) state_next = S_CONS;
      S_CONS: state_next = short_dt ? S_PCT : S_WALK;
      S_PCT:  state_next = needs_div ? S_PDIV : S_OUT;
      S_PDIV: if (div_done) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Playback datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= OP_LOAD;
      trk       <= '0;
      idx       <= '0;
      du        <= '0;
      req_freq_q <= '0;
      dt_rem    <= '0;
      ld_rng    <= 1'b0;
      play_ok   <= 1'b0;
      rd_vld    <= 1'b0;
      active    <= 1'b0;
      done_flag <= 1'b0;
      cur_track <= '0;
      next_note <= '0;
      note_left <= '0;
      played    <= '0;
      period    <= BASE_PERIOD;
      duty      <= '0;
      cur_len   <= '0;
      cur_tot   <= '0;
      status    <= 1'b0;
      pct       <= '0;
      info_vld  <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_fire) begin
          op         <= op_t'(req.operation);
          trk        <= req.track;
          idx        <= req.note_index;
          du         <= req.note_dur;
          req_freq_q <= req.note_freq;
          dt_rem     <= req.tick_ms;
          ld_rng     <= in_trk_rng && (int'(req.note_index) < NOTES);
          play_ok    <= in_play_ok;
          rd_vld     <= info_vld[info_raddr];
          status     <= 1'b0;
        end
        S_EXEC: begin
          case (op)
            OP_LOAD: if (ld_hit) begin
              info_vld[TW'(trk)] <= 1'b1;
              if (TW'(trk) == cur_track) begin
                cur_len <= new_len;
                cur_tot <= new_tot;
              end
            end
            OP_PLAY, OP_STOP: begin
              // Stop first: restore the base tone if a track was running
              if (active) begin
                period <= BASE_PERIOD;
                duty   <= '0;
              end
              active    <= 1'b0;
              done_flag <= 1'b0;
              next_note <= '0;
              note_left <= '0;
              played    <= '0;
              if (op == OP_PLAY) begin
                if (play_ok) begin
                  cur_track <= TW'(trk);
                  active    <= 1'b1;
                  cur_len   <= rd_len;
                  cur_tot   <= rd_tot;
                end else begin
                  status <= 1'b1;
                end
              end
            end
            OP_TICK: if (active && dt_rem != 16'd0) begin
              played <= cons_played;
              if (short_dt) begin
                note_left <= note_left - dt_rem;
              end else begin
                dt_rem    <= dt_rem - note_left;
                note_left <= '0;
              end
            end
            default: ;
          endcase
        end
        S_WALK: if (walk_end) begin
          period    <= BASE_PERIOD;
          duty      <= '0;
          played    <= cur_tot;
          done_flag <= 1'b1;
          active    <= 1'b0;
          next_note <= '0;
          note_left <= '0;
        end
        S_NOTE: begin
          if (nf == 16'd0 && nd == 16'd0) begin
            // End marker: finish playback
            period    <= BASE_PERIOD;
            duty      <= '0;
            played    <= cur_tot;
            done_flag <= 1'b1;
            active    <= 1'b0;
            next_note <= '0;
            note_left <= '0;
          end else begin
            next_note <= next_note + 1'b1;
            note_left <= nd;
            if (nf == 16'd0) duty <= '0;
          end
        end
        S_TDIV: if (div_done) begin
          period <= tone_pm1;
          duty   <= tone_pm1[15:1];
        end
        S_CONS: begin
          played <= cons_played;
          if (short_dt) begin
            note_left <= note_left - dt_rem;
          end else begin
            dt_rem    <= dt_rem - note_left;
            note_left <= '0;
          end
        end
        S_PCT: if (!needs_div) begin
          pct <= (done_flag || (cur_tot != '0 && played >= cur_tot)) ? PCT_FULL : 7'd0;
        end
        S_PDIV: if (div_done) pct <= div_quo[6:0];
        default: ;
      endcase
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      rsp.tone_reload       <= period;
      rsp.tone_compare      <= duty;
      rsp.backlight_compare <= active ? FULL_SCALE : backlight_level;
      rsp.playing           <= active;
      rsp.finished          <= done_flag;
      rsp.elapsed_ms        <= played;
      rsp.total_ms          <= cur_tot;
      rsp.progress_pct      <= pct;
      rsp.status            <= status;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bms_ram.sv @@
`default_nettype none

module bms_ram #(
  parameter int W  = 32,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/bms_div.sv @@
`default_nettype none

module bms_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [bms_pkg::DIV_NW-1:0] num,
  input  wire logic [bms_pkg::DIV_DW-1:0] den,
  output logic                           done,
  output logic      [bms_pkg::DIV_NW-1:0] quo
);
  import bms_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic              run;
  logic [CW-1:0]     cnt;
  logic [DIV_DW:0]   rem;
  logic [DIV_NW-1:0] qs;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_DW:0]   sh;
  logic              ge;

  // Shift in one dividend bit, subtract when the divisor fits
  assign sh  = {rem[DIV_DW-1:0], qs[DIV_NW-1]};
  assign ge  = sh >= {1'b0, den_q};
  assign quo = qs;

  // Control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DIV_NW - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      qs    <= num;
      den_q <= den;
    end else if (run) begin
      rem <= ge ? (sh - {1'b0, den_q}) : sh;
      qs  <= {qs[DIV_NW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bms_checker.sv @@
`default_nettype none

module bms_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] tone_reload,
  input wire logic [14:0] tone_compare,
  input wire logic [15:0] backlight_compare,
  input wire logic        playing,
  input wire logic        finished,
  input wire logic [23:0] elapsed_ms,
  input wire logic [23:0] total_ms,
  input wire logic [6:0]  progress_pct,
  input wire logic        status
);
  import bms_pkg::*;

  // Backlight goes full scale during playback
  a_backlight_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && playing |-> backlight_compare == FULL_SCALE)
    else $error("backlight not full scale while playing");

  // Outside playback the buzzer sits at its base settings
  a_idle_tone: assert property (@(posedge clk) disable iff (rst)
    out_valid && !playing |-> tone_reload == BASE_PERIOD && tone_compare == 15'd0)
    else $error("base tone not restored while idle");

  // Natural end stops playback and pins progress; later loads may change the total
  a_finish: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> !playing && progress_pct == PCT_FULL)
    else $error("finished transaction inconsistent");

  // A rejected play leaves nothing running
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !playing && !finished)
    else $error("rejected play left track running");

  // Stalled response holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(elapsed_ms) && $stable(status))
    else $error("stalled response changed");

endmodule

bind buzzer_melody_sequencer_unit bms_checker u_bms_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (rsp.valid),
  .out_ready         (rsp.ready),
  .tone_reload       (rsp.tone_reload),
  .tone_compare      (rsp.tone_compare),
  .backlight_compare (rsp.backlight_compare),
  .playing           (rsp.playing),
  .finished          (rsp.finished),
  .elapsed_ms        (rsp.elapsed_ms),
  .total_ms          (rsp.total_ms),
  .progress_pct      (rsp.progress_pct),
  .status            (rsp.status)
);

`default_nettype wire

@@ dv/buzzer_melody_sequencer_unit_test.sv @@
`timescale 1ns / 1ps

module buzzer_melody_sequencer_unit_test;
  import bms_pkg::*;

  localparam int NTRK = 16;
  localparam int NNOTE = 256;
  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct packed {
    op_t         operation;
    logic [3:0]  track;
    logic [7:0]  note_index;
    logic [15:0] note_freq;
    logic [15:0] note_dur;
    logic [15:0] tick_ms;
  } request_t;

  typedef struct packed {
    logic [15:0] tone_reload;
    logic [14:0] tone_compare;
    logic [15:0] backlight_compare;
    logic        playing;
    logic        finished;
    logic [23:0] elapsed_ms;
    logic [23:0] total_ms;
    logic [6:0]  progress_pct;
    logic        status;
  } snapshot_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  bms_in_if req ();
  bms_out_if rsp ();

  buzzer_melody_sequencer_unit dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req.sink), .rsp(rsp.source)
  );

  // Sequencer shadow state
  logic [15:0] mel_freq [NTRK*NNOTE];
  logic [15:0] mel_dur [NTRK*NNOTE];
  int unsigned mel_len [NTRK];
  int unsigned mel_total [NTRK];
  bit          sh_active;
  int unsigned sh_track;
  int unsigned sh_next;
  int unsigned sh_left;
  int unsigned sh_played;
  bit          sh_done;
  int unsigned sh_period;
  int unsigned sh_duty;
  int unsigned sh_count;
  int unsigned sh_backlight;

  request_t  pending_requests[$];
  snapshot_t expected_snapshots[$];
  int  errors;
  int  accepted_in;
  int  accepted_out;
  int  watchdog;
  int  plays_seen;
  int  finishes_seen;
  bit  in_quiet;
  bit  out_quiet;
  bit  in_taken;

  function automatic int unsigned sat24(int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > 64'hFFFFFF) ? 32'hFFFFFF : int'(s);
  endfunction

  function automatic void tone_for(int unsigned f);
    int unsigned per;
    if (f == 0) begin
      sh_duty = 0;
      return;
    end
    per = 1000000 / f;
    if (per < 2) per = 2;
    if (per > 65535) per = 65535;
    sh_period = per - 1;
    sh_duty = (per - 1) / 2;
  endfunction

  function automatic void halt_melody();
    if (sh_active) begin
      sh_period = BASE_PERIOD;
      sh_duty = 0;
    end
    sh_active = 0;
    sh_done = 0;
    sh_next = 0;
    sh_left = 0;
    sh_played = 0;
  endfunction

  function automatic void end_melody();
    sh_period = BASE_PERIOD;
    sh_duty = 0;
    sh_played = mel_total[sh_track];
    sh_done = 1;
    sh_active = 0;
    sh_next = 0;
    sh_left = 0;
  endfunction

  function automatic void advance_time(int unsigned dt);
    int unsigned at;
    if (!sh_active || dt == 0) return;
    if (sh_left > 0) begin
      if (dt < sh_left) begin
        sh_left -= dt;
        sh_played = sat24(sh_played, dt);
        return;
      end
      dt -= sh_left;
      sh_played = sat24(sh_played, sh_left);
      sh_left = 0;
    end
    for (int g = 0; g <= NNOTE; g++) begin
      if (sh_next >= mel_len[sh_track] || sh_next >= NNOTE) begin
        end_melody();
        return;
      end
      at = sh_track * NNOTE + sh_next;
      sh_next++;
      if (mel_freq[at] == 0 && mel_dur[at] == 0) begin
        end_melody();
        return;
      end
      tone_for(mel_freq[at]);
      sh_left = mel_dur[at];
      if (dt < sh_left) begin
        sh_left -= dt;
        sh_played = sat24(sh_played, dt);
        return;
      end
      dt -= sh_left;
      sh_played = sat24(sh_played, sh_left);
      sh_left = 0;
    end
    end_melody();
  endfunction

  function automatic snapshot_t predict_snapshot(request_t r);
    snapshot_t s;
    int unsigned cnt;
    int unsigned tot;
    longint unsigned p;
    bit rej;
    rej = 0;
    case (r.operation)
      OP_LOAD: begin
        if (r.note_index == 0) begin
          mel_len[r.track] = 0;
          mel_total[r.track] = 0;
        end
        if (r.note_index == mel_len[r.track]) begin
          mel_freq[r.track*NNOTE + r.note_index] = r.note_freq;
          mel_dur[r.track*NNOTE + r.note_index] = r.note_dur;
          mel_len[r.track] = r.note_index + 1;
          mel_total[r.track] = sat24(mel_total[r.track], r.note_dur);
        end
      end
      OP_PLAY: begin
        cnt = sh_count;
        halt_melody();
        if (cnt > 16) cnt = 16;
        if (r.track >= cnt) rej = 1;
        else begin
          sh_track = r.track;
          sh_active = 1;
          plays_seen++;
        end
      end
      OP_STOP: halt_melody();
      default: begin
        advance_time(r.tick_ms);
        if (sh_done && !sh_active && sh_played == mel_total[sh_track]) finishes_seen += 0;
      end
    endcase
    tot = mel_total[sh_track];
    if (sh_done) p = 100;
    else if (tot == 0) p = 0;
    else begin
      p = (longint'(sh_played) * 100) / tot;
      if (p > 100) p = 100;
    end
    s.tone_reload = sh_period[15:0];
    s.tone_compare = sh_duty[14:0];
    s.backlight_compare = sh_active ? 16'hFFFF : sh_backlight[15:0];
    s.playing = sh_active;
    s.finished = sh_done;
    s.elapsed_ms = sh_played[23:0];
    s.total_ms = tot[23:0];
    s.progress_pct = p[6:0];
    s.status = rej;
    return s;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Drive requests at the falling edge; hold a transaction until it is taken
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !in_taken) begin
      // hold until accepted
    end else if (pending_requests.size() > 0 && (in_quiet || $urandom_range(99) >= 16)) begin
      {req.operation, req.track, req.note_index, req.note_freq, req.note_dur, req.tick_ms}
        <= pending_requests.pop_front();
      req.valid <= 1'b1;
    end else begin
      req.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    rsp.ready <= rst ? 1'b0 : (out_quiet || $urandom_range(99) >= 16);
  end

  // Predict on accepted requests, check accepted responses
  always @(posedge clk) begin
    snapshot_t got;
    snapshot_t exp_s;
    request_t r;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= req.valid && req.ready;
      watchdog <= ((req.valid && req.ready) || (rsp.valid && rsp.ready)) ? 0 : watchdog + 1;
      if (req.valid && req.ready) begin
        r = {op_t'(req.operation), req.track, req.note_index, req.note_freq, req.note_dur,
             req.tick_ms};
        expected_snapshots.push_back(predict_snapshot(r));
        accepted_in++;
      end
      if (rsp.valid && rsp.ready) begin
        accepted_out++;
        got = {rsp.tone_reload, rsp.tone_compare, rsp.backlight_compare, rsp.playing,
               rsp.finished, rsp.elapsed_ms, rsp.total_ms, rsp.progress_pct, rsp.status};
        if (got.finished) finishes_seen++;
        if (expected_snapshots.size() == 0) begin
          errors++;
          $display("%0t: unexpected response %h", $time, got);
        end else begin
          exp_s = expected_snapshots.pop_front();
          if (got !== exp_s) begin
            errors++;
            $display("%0t: mismatch expected reload=%0d cmp=%0d bl=%0d play=%0d fin=%0d el=%0d tot=%0d pct=%0d st=%0d",
                     $time, exp_s.tone_reload, exp_s.tone_compare, exp_s.backlight_compare,
                     exp_s.playing, exp_s.finished, exp_s.elapsed_ms, exp_s.total_ms,
                     exp_s.progress_pct, exp_s.status);
            $display("%0t:          actual   reload=%0d cmp=%0d bl=%0d play=%0d fin=%0d el=%0d tot=%0d pct=%0d st=%0d",
                     $time, got.tone_reload, got.tone_compare, got.backlight_compare,
                     got.playing, got.finished, got.elapsed_ms, got.total_ms,
                     got.progress_pct, got.status);
          end
        end
      end
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d responses outstanding", expected_snapshots.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic queue_req(op_t op, int trk, int idx, int f, int d, int dt);
    request_t r;
    r.operation = op;
    r.track = 4'(trk);
    r.note_index = 8'(idx);
    r.note_freq = 16'(f);
    r.note_dur = 16'(d);
    r.tick_ms = 16'(dt);
    pending_requests.push_back(r);
  endtask

  // Register write while the block is idle
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_TRACK_COUNT) sh_count = value & 32'h1F;
    else sh_backlight = value & 32'hFFFF;
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || expected_snapshots.size() > 0 || req.valid)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Random note value biased toward short durations and musical frequencies
  function automatic int pick_freq();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(65535);
      2: return $urandom_range(15);
      default: return $urandom_range(2000, 100);
    endcase
  endfunction

  function automatic int pick_dur();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(65535);
      default: return $urandom_range(300);
    endcase
  endfunction

  task automatic queue_melody(int trk, int len);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1 && $urandom_range(3) == 0) queue_req(OP_LOAD, trk, i, 0, 0, $urandom);
      else queue_req(OP_LOAD, trk, i, pick_freq(), pick_dur(), $urandom);
    end
  endtask

  initial begin
    int phase_items;
    int unsigned cnt_set [4];
    int unsigned bl_set [4];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.operation = OP_LOAD;
    req.track = '0;
    req.note_index = '0;
    req.note_freq = '0;
    req.note_dur = '0;
    req.tick_ms = '0;
    rsp.ready = 1'b0;
    in_quiet = 0;
    out_quiet = 0;
    errors = 0;
    watchdog = 0;
    plays_seen = 0;
    finishes_seen = 0;
    for (int t = 0; t < NTRK; t++) begin
      mel_len[t] = 0;
      mel_total[t] = 0;
    end
    sh_active = 0; sh_track = 0; sh_next = 0; sh_left = 0; sh_played = 0; sh_done = 0;
    sh_period = BASE_PERIOD; sh_duty = 0; sh_count = 0; sh_backlight = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: play rejected with zero count, loads, extremes, rest and zero notes
    queue_req(OP_PLAY, 0, 0, 0, 0, 0);
    queue_req(OP_TICK, 0, 0, 0, 0, 5);
    drain();
    write_reg(REG_TRACK_COUNT, 32'd16);
    write_reg(REG_BACKLIGHT, 32'hFFFF);
    queue_req(OP_LOAD, 15, 0, 65535, 65535, 0);
    queue_req(OP_LOAD, 15, 1, 0, 100, 0);
    queue_req(OP_LOAD, 15, 2, 1, 0, 0);
    queue_req(OP_LOAD, 15, 3, 16, 50, 0);
    queue_req(OP_LOAD, 15, 9, 440, 50, 0);
    queue_req(OP_LOAD, 15, 4, 0, 0, 0);
    queue_req(OP_PLAY, 15, 0, 0, 0, 0);
    queue_req(OP_TICK, 0, 0, 0, 0, 0);
    queue_req(OP_TICK, 0, 0, 0, 0, 65535);
    queue_req(OP_TICK, 0, 0, 0, 0, 120);
    queue_req(OP_TICK, 0, 0, 0, 0, 65535);
    queue_req(OP_LOAD, 14, 0, 1000, 65535, 0);
    queue_req(OP_PLAY, 14, 255, 0, 0, 0);
    queue_req(OP_TICK, 0, 0, 0, 0, 10);
    queue_req(OP_STOP, 0, 0, 0, 0, 0);
    queue_req(OP_TICK, 0, 0, 0, 0, 10);
    queue_req(OP_PLAY, 3, 0, 0, 0, 0);
    queue_req(OP_TICK, 0, 0, 0, 0, 1);
    drain();

    cnt_set = '{0, 31, 5, 16};
    bl_set = '{0, 65535, 1234, 32768};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_TRACK_COUNT, (ph < 4) ? cnt_set[ph] : $urandom_range(31));
      write_reg(REG_BACKLIGHT, (ph < 4) ? bl_set[ph] : $urandom_range(65535));
      in_quiet = (ph == 5);
      out_quiet = (ph == 5);
      phase_items = 0;
      while (phase_items < 95) begin
        int trk;
        trk = $urandom_range(15);
        case ($urandom_range(9))
          0, 1, 2: begin
            int len;
            len = $urandom_range(6, 1);
            queue_melody(trk, len);
            phase_items += len;
          end
          3: begin
            queue_req(OP_LOAD, trk, $urandom_range(255), $urandom, $urandom, $urandom);
            phase_items++;
          end
          4: begin
            queue_req(OP_STOP, trk, $urandom, $urandom, $urandom, $urandom);
            phase_items++;
          end
          default: begin
            int n;
            queue_req(OP_PLAY, ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(4),
                      $urandom, $urandom, $urandom, $urandom);
            n = $urandom_range(6, 1);
            for (int k = 0; k < n; k++)
              queue_req(OP_TICK, $urandom, $urandom, $urandom, $urandom,
                        ($urandom_range(9) == 0) ? $urandom : $urandom_range(400));
            phase_items += n + 1;
          end
        endcase
      end
      drain();
    end

    $display("Covered %0d requests and %0d responses over 9 register settings,",
             accepted_in, accepted_out);
    $display("with %0d started melodies and %0d finished snapshots.", plays_seen, finishes_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bms_pkg.sv
rtl/core/bms_if.sv
rtl/core/bms_ram.sv
rtl/core/bms_div.sv
rtl/core/buzzer_melody_sequencer_unit.sv
rtl/core/bms_checker.sv
dv/buzzer_melody_sequencer_unit_test.sv
